// ===== rtl/masseq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the mux ADC scan sequencer.
package masseq_pkg;

    localparam int NUM_BOARDS   = 8;
    localparam int NUM_CHANNELS = 16;

    localparam int TICK_W   = 32;
    localparam int THR_W    = 16;
    localparam int MASK_W   = 8;
    localparam int CHV_W    = 64;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 3;
    localparam int ACT_W    = 2;
    localparam int BRD_W    = 3;
    localparam int CH_W     = 4;
    localparam int BCNT_W   = $clog2(NUM_BOARDS + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETTLE   = 3'd0,
        REG_CONVERT  = 3'd1,
        REG_BRD_MASK = 3'd2,
        REG_CHV_LO   = 3'd3,
        REG_CHV_HI   = 3'd4
    } cfg_reg_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_STROBE  = 2'd0,
        ACT_TRIGGER = 2'd1,
        ACT_READ    = 2'd2
    } action_t;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_SWITCH  = 6'b000010,
        PH_SETTLE  = 6'b000100,
        PH_TRIGGER = 6'b001000,
        PH_CONVERT = 6'b010000,
        PH_READ    = 6'b100000
    } phase_t;

    typedef enum logic [3:0] {
        C_IDLE   = 4'b0001,
        C_CALC   = 4'b0010,
        C_DECIDE = 4'b0100,
        C_SCAN   = 4'b1000
    } ctl_t;

endpackage

// ===== rtl/mux_adc_scan_sequencer.sv =====
`timescale 1ns / 1ps
// Mux ADC scan sequencer: phase control, board scan and result register.
//
// Each input transaction (in_valid, in_stall, now_ticks) is one scheduler call.
// The block answers with zero or more result transactions (out_valid,
// out_stall, action, board, channel, last); last marks the final one of a call.
// Phases per channel: mux strobe, settle wait, trigger, convert wait, read.
// The elapsed time (now_ticks minus phase start, modulo 2^32) is formed by one
// shared subtractor and checked by one shared compare against the selected
// threshold; a small sequencer then steps a board counter, one board a cycle
// unless a read waits for a result held by out_stall. A strobe or trigger is
// registered in the decide state, once the output register is free, after the
// elapsed time is formed; a read call emits one read result per enabled board
// and channel, then a last mux strobe for the next channel, and ends there.
// in_stall stays high while a call is in work. A finished result sits in an
// output register, so the next call is accepted while that result waits.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are taken
// in every cycle; indexes above 4 are ignored.
// Reset: phase idle, channel 0, phase start 0, settle 15, convert 9, masks 0,
// no result pending.
module mux_adc_scan_sequencer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [masseq_pkg::TICK_W-1:0]     now_ticks,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [masseq_pkg::ACT_W-1:0]      action,
    output logic [masseq_pkg::BRD_W-1:0]      board,
    output logic [masseq_pkg::CH_W-1:0]       channel,
    output logic                              last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [masseq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [masseq_pkg::CFG_W-1:0]      cfg_data
);
    import masseq_pkg::*;

    logic [THR_W-1:0]  settle_reg;
    logic [THR_W-1:0]  convert_reg;
    logic [MASK_W-1:0] brd_mask_reg;
    logic [CHV_W-1:0]  chv_lo_reg;
    logic [CHV_W-1:0]  chv_hi_reg;

    ctl_t              ctl_reg, ctl_next;
    phase_t            phase_reg, phase_next;
    logic [CH_W-1:0]   chan_reg, chan_next;
    logic [TICK_W-1:0] start_reg, start_next;
    logic [BCNT_W-1:0] bidx_reg, bidx_next;
    logic [TICK_W-1:0] now_reg;
    logic [TICK_W-1:0] elapsed_reg;

    logic              out_valid_reg, out_valid_next;
    action_t           act_reg, act_next;
    logic [BRD_W-1:0]  brd_reg, brd_next;
    logic [CH_W-1:0]   och_reg, och_next;
    logic              last_reg, last_next;

    logic              out_free;
    logic [THR_W-1:0]  thr;
    logic              over;
    logic [CH_W-1:0]   chan_adv;
    logic              hit;
    logic [2*CHV_W-1:0] chv_all;
    logic              scan_done;

    assign cfg_ready = 1'b1;
    assign in_stall  = (ctl_reg != C_IDLE);
    assign out_valid = out_valid_reg;
    assign action    = act_reg;
    assign board     = brd_reg;
    assign channel   = och_reg;
    assign last      = last_reg;

    assign out_free  = !out_valid_reg || !out_stall;
    assign thr       = (phase_reg == PH_SETTLE) ? settle_reg : convert_reg;
    assign over      = elapsed_reg > {{(TICK_W-THR_W){1'b0}}, thr};
    assign chan_adv  = (chan_reg >= CH_W'(NUM_CHANNELS - 1)) ? '0 : chan_reg + 1'b1;
    assign chv_all   = {chv_hi_reg, chv_lo_reg};
    assign hit       = brd_mask_reg[bidx_reg[BRD_W-1:0]]
                       && chv_all[{bidx_reg[BRD_W-1:0], chan_reg}];
    assign scan_done = (bidx_reg == BCNT_W'(NUM_BOARDS));

    always_comb
    begin
        ctl_next       = ctl_reg;
        phase_next     = phase_reg;
        chan_next      = chan_reg;
        start_next     = start_reg;
        bidx_next      = bidx_reg;
        out_valid_next = out_valid_reg && out_stall;
        act_next       = act_reg;
        brd_next       = brd_reg;
        och_next       = och_reg;
        last_next      = last_reg;

        unique case (ctl_reg)
            C_IDLE:
            begin
                if (in_valid)
                begin
                    ctl_next = C_CALC;
                end
            end
            C_CALC:
            begin
                ctl_next = C_DECIDE;
            end
            C_DECIDE:
            begin
                unique case (phase_reg)
                    PH_SWITCH:
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            act_next       = ACT_STROBE;
                            brd_next       = '0;
                            och_next       = chan_reg;
                            last_next      = 1'b1;
                            start_next     = now_reg;
                            phase_next     = PH_SETTLE;
                            ctl_next       = C_IDLE;
                        end
                    end
                    PH_SETTLE:
                    begin
                        if (over)
                        begin
                            phase_next = PH_TRIGGER;
                        end
                        ctl_next = C_IDLE;
                    end
                    PH_TRIGGER:
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            act_next       = ACT_TRIGGER;
                            brd_next       = '0;
                            och_next       = chan_reg;
                            last_next      = 1'b1;
                            start_next     = now_reg;
                            phase_next     = PH_CONVERT;
                            ctl_next       = C_IDLE;
                        end
                    end
                    PH_CONVERT:
                    begin
                        if (over)
                        begin
                            phase_next = PH_READ;
                        end
                        ctl_next = C_IDLE;
                    end
                    PH_READ:
                    begin
                        bidx_next = '0;
                        ctl_next  = C_SCAN;
                    end
                    default:
                    begin
                        phase_next = PH_SWITCH;
                        ctl_next   = C_IDLE;
                    end
                endcase
            end
            C_SCAN:
            begin
                if (scan_done)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        act_next       = ACT_STROBE;
                        brd_next       = '0;
                        och_next       = chan_adv;
                        last_next      = 1'b1;
                        chan_next      = chan_adv;
                        start_next     = now_reg;
                        phase_next     = PH_SETTLE;
                        ctl_next       = C_IDLE;
                    end
                end
                else if (hit)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        act_next       = ACT_READ;
                        brd_next       = bidx_reg[BRD_W-1:0];
                        och_next       = chan_reg;
                        last_next      = 1'b0;
                        bidx_next      = bidx_reg + 1'b1;
                    end
                end
                else
                begin
                    bidx_next = bidx_reg + 1'b1;
                end
            end
            default:
            begin
                ctl_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg       <= C_IDLE;
            phase_reg     <= PH_IDLE;
            chan_reg      <= '0;
            start_reg     <= '0;
            bidx_reg      <= '0;
            out_valid_reg <= 1'b0;
            settle_reg    <= THR_W'(15);
            convert_reg   <= THR_W'(9);
            brd_mask_reg  <= '0;
            chv_lo_reg    <= '0;
            chv_hi_reg    <= '0;
        end
        else
        begin
            ctl_reg       <= ctl_next;
            phase_reg     <= phase_next;
            chan_reg      <= chan_next;
            start_reg     <= start_next;
            bidx_reg      <= bidx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_SETTLE:   settle_reg   <= cfg_data[THR_W-1:0];
                    REG_CONVERT:  convert_reg  <= cfg_data[THR_W-1:0];
                    REG_BRD_MASK: brd_mask_reg <= cfg_data[MASK_W-1:0];
                    REG_CHV_LO:   chv_lo_reg   <= cfg_data[CHV_W-1:0];
                    REG_CHV_HI:   chv_hi_reg   <= cfg_data[CHV_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            now_reg <= now_ticks;
        end
        if (ctl_reg == C_CALC)
        begin
            elapsed_reg <= now_reg - start_reg;
        end
        act_reg  <= act_next;
        brd_reg  <= brd_next;
        och_reg  <= och_next;
        last_reg <= last_next;
    end

`ifndef ASSERT_OFF
    a_scan_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg == C_SCAN |-> phase_reg == PH_READ)
        else $error("board scan outside read phase");

    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg == C_SCAN && scan_done && out_free)
        |=> (phase_reg == PH_SETTLE && ctl_reg == C_IDLE && out_valid && last))
        else $error("read call did not close with a last mux strobe");

    a_read_fitted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && action == ACT_READ) |-> (brd_mask_reg[board] && !last))
        else $error("read issued to an unfitted board or marked last");

    a_busy_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg == C_SCAN) |-> in_stall)
        else $error("input taken during board scan");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Testbench for mux_adc_scan_sequencer: scheduler calls in, scan actions checked against a predictor.
module tb;

    import masseq_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef struct {
        action_t              act;
        logic [BRD_W-1:0]     brd;
        logic [CH_W-1:0]      ch;
        logic                 lst;
    } scan_action_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [TICK_W-1:0]     now_ticks = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [ACT_W-1:0]      action;
    logic [BRD_W-1:0]      board;
    logic [CH_W-1:0]       channel;
    logic                  last;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;

    scan_action_t          pending_actions[$];
    int                    failures = 0;
    int                    cycles = 0;
    int                    stall_left = 0;
    logic                  hold_off = 1'b0;
    logic                  calm = 1'b0;

    phase_t                model_phase = PH_IDLE;
    logic [CH_W-1:0]       model_chan = '0;
    logic [TICK_W-1:0]     model_start = '0;
    logic [TICK_W-1:0]     tick_now = '0;
    logic [THR_W-1:0]      cfg_settle = 16'd15;
    logic [THR_W-1:0]      cfg_convert = 16'd9;
    logic [MASK_W-1:0]     cfg_boards = '0;
    logic [CHV_W-1:0]      cfg_chv_lo = '0;
    logic [CHV_W-1:0]      cfg_chv_hi = '0;

    mux_adc_scan_sequencer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .now_ticks (now_ticks),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .action    (action),
        .board     (board),
        .channel   (channel),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic void queue_action(input action_t act, input logic [BRD_W-1:0] brd);
        pending_actions.push_back('{act: act, brd: brd, ch: model_chan, lst: 1'b0});
    endfunction

    function automatic void advance_scan(input logic [TICK_W-1:0] t);
        logic [TICK_W-1:0] elapsed;
        logic [CHV_W-1:0]  chv;
        int                emitted;
        elapsed = t - model_start;
        emitted = 0;
        case (model_phase)
            PH_SWITCH:
            begin
                queue_action(ACT_STROBE, '0);
                emitted++;
                model_start = t;
                model_phase = PH_SETTLE;
            end
            PH_SETTLE:
            begin
                if (elapsed > TICK_W'(cfg_settle))
                    model_phase = PH_TRIGGER;
            end
            PH_TRIGGER:
            begin
                queue_action(ACT_TRIGGER, '0);
                emitted++;
                model_start = t;
                model_phase = PH_CONVERT;
            end
            PH_CONVERT:
            begin
                if (elapsed > TICK_W'(cfg_convert))
                    model_phase = PH_READ;
            end
            PH_READ:
            begin
                for (int b = 0; b < NUM_BOARDS; b++)
                begin
                    chv = (b < 4) ? cfg_chv_lo : cfg_chv_hi;
                    if (cfg_boards[b] && chv[(b % 4) * 16 + model_chan])
                    begin
                        queue_action(ACT_READ, BRD_W'(b));
                        emitted++;
                    end
                end
                model_chan = (model_chan == CH_W'(NUM_CHANNELS - 1)) ? '0 : model_chan + 1'b1;
                queue_action(ACT_STROBE, '0);
                emitted++;
                model_start = t;
                model_phase = PH_SETTLE;
            end
            default:
                model_phase = PH_SWITCH;
        endcase
        if (emitted > 0)
            pending_actions[pending_actions.size() - 1].lst = 1'b1;
    endfunction

    // Aim the tick at the wait boundaries so that scans run through every phase.
    function automatic logic [TICK_W-1:0] pick_ticks();
        logic [TICK_W-1:0] thr;
        int                roll;
        roll = $urandom_range(0, 11);
        if (model_phase == PH_SETTLE || model_phase == PH_CONVERT)
        begin
            thr = (model_phase == PH_SETTLE) ? TICK_W'(cfg_settle) : TICK_W'(cfg_convert);
            case (roll)
                0, 1:    tick_now = model_start + thr;
                2, 3, 4: tick_now = model_start + thr + 1;
                5:       tick_now = $urandom;
                6, 7:    tick_now = model_start + $urandom_range(0, thr);
                default: tick_now = model_start + thr + 1 + $urandom_range(0, 40);
            endcase
        end
        else if (roll == 0)
            tick_now = $urandom;
        else
            tick_now = tick_now + $urandom_range(0, 40);
        return tick_now;
    endfunction

    function automatic logic [THR_W-1:0] rand_threshold();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return THR_W'($urandom_range(1, 20));
            default: return THR_W'($urandom);
        endcase
    endfunction

    task automatic send_call(input logic [TICK_W-1:0] t);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        now_ticks <= t;
        tick_now = t;
        do @(posedge clk); while (in_stall);
        advance_scan(t);
    endtask

    task automatic run_calls(input int count);
        for (int k = 0; k < count; k++)
            send_call(pick_ticks());
        in_valid <= 1'b0;
    endtask

    task automatic quiesce();
        while (pending_actions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apply_config(input logic [THR_W-1:0] settle, input logic [THR_W-1:0] convert,
                                input logic [MASK_W-1:0] boards, input logic [CHV_W-1:0] lo,
                                input logic [CHV_W-1:0] hi);
        logic [CFG_IDX_W-1:0] idx [6];
        logic [CFG_W-1:0]     val [6];
        idx = '{REG_SPARE, REG_SETTLE, REG_CONVERT, REG_BRD_MASK, REG_CHV_LO, REG_CHV_HI};
        val = '{{$urandom, $urandom}, CFG_W'(settle), CFG_W'(convert), CFG_W'(boards), lo, hi};
        for (int k = 0; k < 6; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            do @(posedge clk); while (!cfg_ready);
            case (idx[k])
                REG_SETTLE:   cfg_settle = val[k][THR_W-1:0];
                REG_CONVERT:  cfg_convert = val[k][THR_W-1:0];
                REG_BRD_MASK: cfg_boards = val[k][MASK_W-1:0];
                REG_CHV_LO:   cfg_chv_lo = val[k];
                REG_CHV_HI:   cfg_chv_hi = val[k];
                default:      ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic test_default_scan();
        logic [TICK_W-1:0] ticks [12];
        ticks = '{32'hFFFF_FFF0, 32'hFFFF_FFF8, 32'h0000_0007, 32'h0000_0008,
                  32'hFFFF_FFFF, 32'h0000_0008, 32'h0000_0009, 32'h0000_0000,
                  32'h0000_0010, 32'h1234_5678, 32'hFFFF_FFFF, 32'h5555_5555};
        for (int k = 0; k < 12; k++)
            send_call(ticks[k]);
        in_valid <= 1'b0;
    endtask

    task automatic test_config_extremes();
        quiesce();
        apply_config('0, '0, '1, '1, '1);
        run_calls(8);
        quiesce();
        apply_config('1, '1, 8'h81, {$urandom, $urandom}, {$urandom, $urandom});
        run_calls(5);
    endtask

    task automatic test_random_scan();
        for (int s = 0; s < 4; s++)
        begin
            quiesce();
            calm <= (s == 2);
            apply_config(rand_threshold(), rand_threshold(),
                         (s == 0) ? '1 : MASK_W'($urandom),
                         (s == 0) ? '1 : {$urandom, $urandom},
                         {$urandom, $urandom});
            run_calls(70);
        end
        calm <= 1'b0;
    endtask

    task automatic test_backpressure();
        quiesce();
        apply_config(16'd2, 16'd1, '1, '1, '1);
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off <= 1'b0;
            end
            run_calls(40);
        join
    endtask

    always @(posedge clk)
    begin : result_pacing
        int draw;
        if (hold_off)
            out_stall <= 1'b1;
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (out_valid && !out_stall && !calm)
        begin
            draw = $urandom_range(0, 4);
            out_stall  <= (draw != 0);
            stall_left <= (draw == 0) ? 0 : draw - 1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin : result_check
        scan_action_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_actions.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected transaction: action %0d board %0d channel %0d last %0d",
                             action, board, channel, last);
            end
            else
            begin
                want = pending_actions.pop_front();
                if (action !== want.act || board !== want.brd || channel !== want.ch ||
                    last !== want.lst)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 want.act, want.brd, want.ch, want.lst,
                                 action, board, channel, last);
                end
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_default_scan();
        test_config_extremes();
        test_random_scan();
        test_backpressure();
        quiesce();
        if (failures == 0 && pending_actions.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
